>>> rtl/tlb_pkg.sv
package tlb_pkg;

    // Operation codes
    localparam logic [1:0] OP_TRANSLATE = 2'd0;
    localparam logic [1:0] OP_MAP       = 2'd1;
    localparam logic [1:0] OP_UNMAP     = 2'd2;
    localparam logic [1:0] OP_ADVANCE   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FILL  = 2'd1;
    localparam logic [1:0] ST_FAULT = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_OFFSET_WIDTH = 2'd0;
    localparam logic [1:0] CFG_PAGE_WIDTH   = 2'd1;
    localparam logic [1:0] CFG_REPL_MODE    = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [1:0]  process_id;
        logic [15:0] virt_addr;
        logic [7:0]  page_number;
        logic [7:0]  frame_number;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] phys_addr;
        logic [7:0]  frame_found;
        logic [2:0]  tlb_slot;
    } rsp_t;

    typedef struct packed {
        logic [1:0] index;
        logic [3:0] data;
    } cfg_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_TABLE,
        S_OUTPUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_step;
        logic capture;
        logic lookup;
        logic table_step;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_done;
        logic scan_busy;
    } sts_t;

endpackage

>>> rtl/tlb_ctrl.sv
module tlb_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  tlb_pkg::sts_t sts,
    output tlb_pkg::cmd_t cmd
);
    import tlb_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // Result register can take a new result when empty or being drained
    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:  if (sts.clear_done) state_next = S_IDLE;
            S_IDLE:   if (in_valid && !sts.scan_busy) state_next = S_LOOKUP;
            S_LOOKUP: state_next = S_TABLE;
            S_TABLE:  state_next = S_OUTPUT;
            S_OUTPUT: if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:  cmd.clear_step = 1'b1;
            S_IDLE:
            begin
                // hold off while the victim scan is still running
                in_ready    = !sts.scan_busy;
                cmd.capture = in_valid && !sts.scan_busy;
            end
            S_LOOKUP: cmd.lookup = 1'b1;
            S_TABLE:  cmd.table_step = 1'b1;
            S_OUTPUT: cmd.out_load = out_free;
            default:  cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready) out_valid_next = 1'b0;
        if (cmd.out_load) out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_load_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("result not presented");
    a_lookup_seq: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lookup |=> cmd.table_step)
        else $error("table step missing after lookup");
`endif

endmodule

>>> rtl/tlb_dpath.sv
module tlb_dpath #(
    parameter int TLB_ENTRIES     = 8,
    parameter int PROCESS_COUNT   = 4,
    parameter int MAX_PAGE_BITS   = 8,
    parameter int MAX_FRAME_BITS  = 8,
    parameter int MAX_OFFSET_BITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  tlb_pkg::req_t req,
    input  logic          cfg_wr,
    input  tlb_pkg::cfg_t cfg,
    input  tlb_pkg::cmd_t cmd,
    output tlb_pkg::sts_t sts,
    output tlb_pkg::rsp_t rsp
);
    import tlb_pkg::*;

    localparam int SW  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int PCW = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1;
    localparam int DEPTH = PROCESS_COUNT * (2 ** MAX_PAGE_BITS);
    localparam int AW  = $clog2(DEPTH);

    // Configuration
    logic [3:0] offset_width_reg;
    logic [3:0] page_width_reg;
    logic       repl_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_width_reg <= 4'd4;
            page_width_reg   <= 4'd8;
            repl_mode_reg    <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (cfg.index)
                CFG_OFFSET_WIDTH: offset_width_reg <= cfg.data;
                CFG_PAGE_WIDTH:   page_width_reg   <= cfg.data;
                CFG_REPL_MODE:    repl_mode_reg    <= cfg.data[0];
                default:          ;
            endcase
        end
    end

    logic [3:0] ow;
    logic [3:0] pw;
    assign ow = (32'(offset_width_reg) > MAX_OFFSET_BITS) ? 4'(MAX_OFFSET_BITS)
                                                         : offset_width_reg;
    assign pw = (32'(page_width_reg) > MAX_PAGE_BITS) ? 4'(MAX_PAGE_BITS)
                                                     : page_width_reg;

    // Captured request
    req_t       req_reg;
    logic [3:0] ow_reg;
    logic [3:0] pw_reg;
    logic [31:0] time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) time_reg <= '0;
        else if (cmd.capture) time_reg <= time_reg + 32'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
            ow_reg  <= ow;
            pw_reg  <= pw;
        end
    end

    // Decoded fields of the held request
    logic [15:0] va_page;
    logic        pid_ok;
    logic [15:0] lk_page;
    logic        page_fits;
    logic        page_in_tbl;
    logic [15:0] pw_limit;
    logic [15:0] off_mask;
    logic [MAX_FRAME_BITS-1:0] fn_in;

    assign va_page  = req_reg.virt_addr >> ow_reg;
    assign pid_ok   = 32'(req_reg.process_id) < PROCESS_COUNT;
    assign lk_page  = (req_reg.operation == OP_TRANSLATE) ? va_page
                                                         : 16'(req_reg.page_number);
    assign page_fits = 32'(lk_page) < (2 ** MAX_PAGE_BITS);
    assign pw_limit  = 16'(17'd1 << pw_reg) - 16'd1;
    assign page_in_tbl = ({1'b0, lk_page} <= {1'b0, pw_limit}) ||
                         (32'(pw_reg) >= 16);
    assign off_mask  = 16'((17'd1 << ow_reg) - 17'd1);
    assign fn_in     = MAX_FRAME_BITS'(req_reg.frame_number);

    // TLB entries
    logic [TLB_ENTRIES-1:0]    ev_reg;
    logic [MAX_PAGE_BITS-1:0]  ep_reg [TLB_ENTRIES];
    logic [MAX_FRAME_BITS-1:0] ef_reg [TLB_ENTRIES];
    logic [PCW-1:0]            epid_reg [TLB_ENTRIES];
    logic [31:0]               es_reg [TLB_ENTRIES];

    // Parallel tag compare
    logic [TLB_ENTRIES-1:0] match;
    always_comb
    begin
        for (int i = 0; i < TLB_ENTRIES; i++)
            match[i] = ev_reg[i] && page_fits &&
                       (16'(ep_reg[i]) == lk_page) &&
                       (epid_reg[i] == PCW'(req_reg.process_id));
    end

    // Victim choice: first free slot, else oldest stamp from the scan below
    logic [SW-1:0] free_idx;
    logic          any_free;
    logic [SW-1:0] hit_idx;
    logic          hit;
    always_comb
    begin
        free_idx = '0;
        any_free = 1'b0;
        hit_idx  = '0;
        hit      = 1'b0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (!ev_reg[i]) begin free_idx = SW'(i); any_free = 1'b1; end
            if (match[i])   begin hit_idx = SW'(i);  hit = 1'b1; end
        end
    end

    // Oldest-stamp search: one entry per cycle over a scan counter,
    // restarted whenever an entry changes; the controller waits for it
    logic [SW:0]   scan_reg;
    logic [SW-1:0] old_idx_reg;
    logic          ev_stamp_chg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg    <= '0;
            old_idx_reg <= '0;
        end
        else if (scan_reg != '0)
        begin
            if (es_reg[scan_reg[SW-1:0]] < es_reg[old_idx_reg])
                old_idx_reg <= scan_reg[SW-1:0];
            if (32'(scan_reg) == TLB_ENTRIES - 1) scan_reg <= '0;
            else scan_reg <= scan_reg + 1'b1;
        end
        else if (ev_stamp_chg)
        begin
            old_idx_reg <= '0;
            scan_reg    <= (SW+1)'(1);
        end
    end

    // Page table memory with clearing sweep
    logic [AW-1:0] clr_reg;
    logic          clr_last;
    logic          tv_mem [DEPTH];
    logic [MAX_FRAME_BITS-1:0] tf_mem [DEPTH];
    logic          tv_rd_reg;
    logic [MAX_FRAME_BITS-1:0] tf_rd_reg;
    logic [AW-1:0] tbl_addr;
    logic          tbl_ok;

    assign clr_last = 32'(clr_reg) == DEPTH - 1;
    assign sts = '{clear_done: cmd.clear_step && clr_last,
                   scan_busy:  scan_reg != '0};
    assign tbl_addr = AW'(req_reg.process_id) * AW'(2 ** MAX_PAGE_BITS) + AW'(lk_page);
    assign tbl_ok   = pid_ok && page_fits && page_in_tbl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) clr_reg <= '0;
        else if (cmd.clear_step && !clr_last) clr_reg <= clr_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            tv_mem[clr_reg] <= 1'b0;
            tf_mem[clr_reg] <= '0;
        end
        else if (cmd.lookup && tbl_ok && req_reg.operation == OP_MAP)
        begin
            tv_mem[tbl_addr] <= 1'b1;
            tf_mem[tbl_addr] <= fn_in;
        end
        else if (cmd.lookup && tbl_ok && req_reg.operation == OP_UNMAP)
        begin
            tv_mem[tbl_addr] <= 1'b0;
            tf_mem[tbl_addr] <= '0;
        end
        tv_rd_reg <= tv_mem[tbl_addr];
        tf_rd_reg <= tf_mem[tbl_addr];
    end

    // Lookup results held for the table step
    logic          hit_q;
    logic [SW-1:0] hit_idx_q;
    logic          any_free_q;
    logic [SW-1:0] free_idx_q;
    logic          tbl_ok_q;
    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            hit_q      <= hit;
            hit_idx_q  <= hit_idx;
            any_free_q <= any_free;
            free_idx_q <= free_idx;
            tbl_ok_q   <= tbl_ok;
        end
    end

    // Entry update decision in the table step
    logic          is_tr;
    logic          do_write;
    logic [SW-1:0] wr_idx;
    logic [MAX_FRAME_BITS-1:0] wr_frame;
    logic          do_refresh;
    logic          do_inval;
    logic          tr_ok;

    assign is_tr = req_reg.operation == OP_TRANSLATE;
    always_comb
    begin
        do_write   = 1'b0;
        do_refresh = 1'b0;
        do_inval   = 1'b0;
        wr_frame   = fn_in;
        tr_ok      = 1'b0;
        wr_idx     = hit_q ? hit_idx_q : (any_free_q ? free_idx_q : old_idx_reg);
        if (cmd.table_step && pid_ok)
        begin
            case (req_reg.operation)
                OP_TRANSLATE:
                begin
                    if (hit_q)
                    begin
                        tr_ok      = 1'b1;
                        do_refresh = repl_mode_reg;
                    end
                    else if (tbl_ok_q && tv_rd_reg)
                    begin
                        tr_ok    = 1'b1;
                        do_write = 1'b1;
                        wr_frame = tf_rd_reg;
                    end
                end
                OP_MAP:   do_write = 1'b1;
                OP_UNMAP: do_inval = hit_q;
                default:  ;
            endcase
        end
    end
    assign ev_stamp_chg = do_write || do_refresh || do_inval;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_reg <= '0;
            for (int i = 0; i < TLB_ENTRIES; i++) es_reg[i] <= '0;
        end
        else
        begin
            if (do_write)
            begin
                ev_reg[wr_idx] <= 1'b1;
                es_reg[wr_idx] <= time_reg;
            end
            if (do_refresh) es_reg[hit_idx_q] <= time_reg;
            if (do_inval)   ev_reg[hit_idx_q] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            ep_reg[wr_idx]   <= MAX_PAGE_BITS'(lk_page);
            epid_reg[wr_idx] <= PCW'(req_reg.process_id);
            ef_reg[wr_idx]   <= wr_frame;
        end
    end

    // Result formed in the table step, registered for output
    rsp_t res_reg;
    rsp_t res_next;
    logic [MAX_FRAME_BITS-1:0] frame_q;
    always_comb
    begin
        res_next = '0;
        if (is_tr)
        begin
            if (tr_ok)
            begin
                frame_q = hit_q ? ef_reg[hit_idx_q] : tf_rd_reg;
                res_next.status = hit_q ? ST_DONE : ST_FILL;
                res_next.frame_found = 8'(frame_q);
                res_next.phys_addr = (16'(frame_q) << ow_reg) |
                                     (req_reg.virt_addr & off_mask);
                res_next.tlb_slot = 3'(wr_idx);
            end
            else
            begin
                frame_q = '0;
                res_next.status = ST_FAULT;
            end
        end
        else
        begin
            frame_q = '0;
            res_next.status = ST_DONE;
        end
    end

    rsp_t hold_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.table_step) hold_reg <= res_next;
        if (cmd.out_load)   res_reg  <= hold_reg;
    end
    assign rsp = res_reg;

`ifndef SYNTHESIS
    a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lookup |-> $onehot0(match))
        else $error("duplicate TLB tags");
    a_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(do_write && do_inval))
        else $error("fill and invalidate together");
    a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> scan_reg == '0)
        else $error("victim search still running");
`endif

endmodule

>>> rtl/tlb_page_table_translator.sv
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid / in_ready       | in   (tlb_pkg::req_t)
// out     | output    | out_valid / out_ready     | out  (tlb_pkg::rsp_t)
// cfg     | input     | cfg_valid / cfg_ready     | cfg  (tlb_pkg::cfg_t)
//
// One transaction at a time: accept, tag compare, page table read and TLB update,
// then result register. When it writes, refreshes or invalidates a TLB entry, the
// next accept waits for the oldest-stamp scan. After reset the page table's
// PROCESS_COUNT * 2^MAX_PAGE_BITS entries (1024) are swept clear, in_ready low;
// cfg always taken. A stalled result holds the block in its output step with
// in_ready low.
module tlb_page_table_translator #(
    parameter int TLB_ENTRIES     = 8,
    parameter int PROCESS_COUNT   = 4,
    parameter int MAX_PAGE_BITS   = 8,
    parameter int MAX_FRAME_BITS  = 8,
    parameter int MAX_OFFSET_BITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  tlb_pkg::req_t in,
    output logic          out_valid,
    input  logic          out_ready,
    output tlb_pkg::rsp_t out,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  tlb_pkg::cfg_t cfg
);
    import tlb_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    tlb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tlb_dpath #(
        .TLB_ENTRIES     (TLB_ENTRIES),
        .PROCESS_COUNT   (PROCESS_COUNT),
        .MAX_PAGE_BITS   (MAX_PAGE_BITS),
        .MAX_FRAME_BITS  (MAX_FRAME_BITS),
        .MAX_OFFSET_BITS (MAX_OFFSET_BITS)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (in),
        .cfg_wr (cfg_valid),
        .cfg    (cfg),
        .cmd    (cmd),
        .sts    (sts),
        .rsp    (out)
    );

endmodule
